// ===== rtl/core/gct_pkg.sv =====
// ----------------------------------------------------------------------------
// gct_pkg: shared definitions for the glyph column-to-row transpose
// Sizes, register indexes, the page request carried from the front part to
// the back part, and helpers that clamp the configuration registers.
// ----------------------------------------------------------------------------
package gct_pkg;

  // Glyph geometry.
  localparam int MaxWidth  = 16;
  localparam int MaxPages  = 4;
  localparam int PixRows   = 8;
  localparam int PageBits  = MaxWidth * PixRows;
  localparam int ColIdxW   = $clog2(MaxWidth);
  localparam int PageIdxW  = $clog2(MaxPages);
  localparam int RowIdxW   = $clog2(PixRows);
  localparam int BitIdxW   = $clog2(PageBits);
  localparam int WidthW    = 5;
  localparam int PagesW    = 3;

  // Page queue between the front and back parts; the depth is a power of two.
  localparam int QueueDepth = 2;
  localparam int QPtrW      = $clog2(QueueDepth);
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Configuration port.
  localparam int CfgIndexW = 1;
  localparam int CfgDataW  = WidthW;
  localparam logic [CfgIndexW-1:0] REG_GLYPH_WIDTH = 1'b0;
  localparam logic [CfgIndexW-1:0] REG_PAGE_COUNT  = 1'b1;
  localparam logic [WidthW-1:0] GlyphWidthReset = 5'd5;
  localparam logic [PagesW-1:0] PageCountReset  = 3'd1;

  // One finished page: all columns, the width it is packed with, and
  // whether it is the last page of its glyph.
  typedef struct packed {
    logic [PageBits-1:0] bits;
    logic [WidthW-1:0]   width;
    logic                last_page;
  } job_t;

  // Page queue status seen by both sides.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Width register clamped to 1..MaxWidth.
  function automatic logic [WidthW-1:0] eff_width(input logic [WidthW-1:0] gw);
    logic [WidthW-1:0] w;
    if (gw == '0) begin
      w = WidthW'(1);
    end else if (gw > WidthW'(MaxWidth)) begin
      w = WidthW'(MaxWidth);
    end else begin
      w = gw;
    end
    return w;
  endfunction

  // Page count register clamped to 1..MaxPages.
  function automatic logic [PagesW-1:0] eff_pages(input logic [PagesW-1:0] pc);
    logic [PagesW-1:0] p;
    if (pc == '0) begin
      p = PagesW'(1);
    end else if (pc > PagesW'(MaxPages)) begin
      p = PagesW'(MaxPages);
    end else begin
      p = pc;
    end
    return p;
  endfunction

endpackage

// ===== rtl/core/gct_if.sv =====
// ----------------------------------------------------------------------------
// gct_if: valid/ready channels of the glyph column-to-row transpose
// The column channel carries one font byte per request, the row channel one
// packed bitmap byte with its page and glyph end marks.
// ----------------------------------------------------------------------------
interface gct_col_if;
  logic       valid;
  logic       ready;
  logic [7:0] column_byte;

  modport source (output valid, output column_byte, input ready);
  modport sink   (input valid, input column_byte, output ready);
endinterface

interface gct_row_if;
  logic       valid;
  logic       ready;
  logic [7:0] row_byte;
  logic       page_done;
  logic       glyph_done;

  modport source (output valid, output row_byte, output page_done,
                  output glyph_done, input ready);
  modport sink   (input valid, input row_byte, input page_done,
                  input glyph_done, output ready);
endinterface

// ===== rtl/core/gct_front.sv =====
// ----------------------------------------------------------------------------
// gct_front: column intake
// Accepts column bytes, keeps the columns of the current page and tracks the
// column and page position. On the last column of a page it pushes the whole
// page into the page queue.
// ----------------------------------------------------------------------------
module gct_front (
  input  logic                       clk,
  input  logic                       rst,
  gct_col_if.sink                    columns,
  input  logic [gct_pkg::WidthW-1:0] width,
  input  logic [gct_pkg::PagesW-1:0] pages,
  input  gct_pkg::q_status_t         q_status,
  output logic                       push,
  output gct_pkg::job_t              job
);

  logic [7:0]                     column_store [gct_pkg::MaxWidth];
  logic [gct_pkg::ColIdxW-1:0]    column_index;
  logic [gct_pkg::PageIdxW-1:0]   page_index;
  logic                           accept;
  logic                           page_end;
  logic                           last_page;

  // A request is taken whenever the queue has room for a page.
  assign columns.ready = !q_status.full;
  assign accept        = columns.valid && columns.ready;

  // Page and glyph end under the current width and page count.
  assign page_end  = ({1'b0, column_index} + gct_pkg::WidthW'(1)) >= width;
  assign last_page = ({1'b0, page_index} + gct_pkg::PagesW'(1)) >= pages;
  assign push      = accept && page_end;

  // Page image with the incoming byte merged into its slot.
  always_comb begin
    for (int c = 0; c < gct_pkg::MaxWidth; c++) begin
      if (gct_pkg::ColIdxW'(c) == column_index) begin
        job.bits[c*gct_pkg::PixRows +: gct_pkg::PixRows] = columns.column_byte;
      end else begin
        job.bits[c*gct_pkg::PixRows +: gct_pkg::PixRows] = column_store[c];
      end
    end
    job.width     = width;
    job.last_page = last_page;
  end

  // Column storage.
  always_ff @(posedge clk) begin
    if (accept) begin
      column_store[column_index] <= columns.column_byte;
    end
  end

  // Column and page counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      column_index <= '0;
      page_index   <= '0;
    end else if (accept) begin
      if (page_end) begin
        column_index <= '0;
        page_index   <= last_page ? '0 : page_index + gct_pkg::PageIdxW'(1);
      end else begin
        column_index <= column_index + gct_pkg::ColIdxW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/gct_queue.sv =====
// ----------------------------------------------------------------------------
// gct_queue: page queue
// A short first-in first-out store of finished pages that lets the intake
// and the output side stall independently.
// ----------------------------------------------------------------------------
module gct_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  gct_pkg::job_t      job_in,
  input  logic               pop,
  output gct_pkg::job_t      job_out,
  output gct_pkg::q_status_t status
);

  gct_pkg::job_t              entries [gct_pkg::QueueDepth];
  logic [gct_pkg::QPtrW-1:0]  wr_ptr;
  logic [gct_pkg::QPtrW-1:0]  rd_ptr;
  logic [gct_pkg::QCntW-1:0]  count;

  assign status.full  = count == gct_pkg::QCntW'(gct_pkg::QueueDepth);
  assign status.empty = count == '0;
  assign job_out      = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= job_in;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + gct_pkg::QPtrW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + gct_pkg::QPtrW'(1);
      end
      if (push && !pop) begin
        count <= count + gct_pkg::QCntW'(1);
      end else if (pop && !push) begin
        count <= count - gct_pkg::QCntW'(1);
      end
    end
  end

endmodule

// ===== rtl/core/gct_back.sv =====
// ----------------------------------------------------------------------------
// gct_back: row packer
// Takes one page from the queue and emits its pixels in row-major order, eight
// per byte, one byte per cycle into the output register while it is free.
// ----------------------------------------------------------------------------
module gct_back (
  input  logic               clk,
  input  logic               rst,
  input  gct_pkg::job_t      job,
  input  gct_pkg::q_status_t q_status,
  output logic               pop,
  gct_row_if.source          rows
);

  gct_pkg::job_t                cur;
  logic                         busy;
  logic [gct_pkg::ColIdxW-1:0]  byte_idx;
  logic [gct_pkg::RowIdxW-1:0]  row_pos;
  logic [gct_pkg::ColIdxW-1:0]  col_pos;
  logic [gct_pkg::RowIdxW-1:0]  row_pos_next;
  logic [gct_pkg::ColIdxW-1:0]  col_pos_next;
  logic [7:0]                   packed_byte;
  logic                         out_free;
  logic                         last_byte;

  assign out_free  = !rows.valid || rows.ready;
  assign pop       = !busy && !q_status.empty;
  assign last_byte = ({1'b0, byte_idx} + gct_pkg::WidthW'(1)) == cur.width;

  // Walk eight pixels from the current (row, column), wrapping at the width.
  always_comb begin
    logic [gct_pkg::RowIdxW-1:0] r;
    logic [gct_pkg::ColIdxW-1:0] c;
    r = row_pos;
    c = col_pos;
    for (int k = 0; k < 8; k++) begin
      packed_byte[7-k] = cur.bits[{c, r}];
      if (({1'b0, c} + gct_pkg::WidthW'(1)) == cur.width) begin
        c = '0;
        r = r + gct_pkg::RowIdxW'(1);
      end else begin
        c = c + gct_pkg::ColIdxW'(1);
      end
    end
    row_pos_next = r;
    col_pos_next = c;
  end

  // Page sequencing and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      rows.valid <= 1'b0;
    end else begin
      if (pop) begin
        busy <= 1'b1;
      end else if (busy && out_free && last_byte) begin
        busy <= 1'b0;
      end
      if (busy && out_free) begin
        rows.valid <= 1'b1;
      end else if (rows.valid && rows.ready) begin
        rows.valid <= 1'b0;
      end
    end
  end

  // Page registers, walk position and output payload.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur      <= job;
      byte_idx <= '0;
      row_pos  <= '0;
      col_pos  <= '0;
    end else if (busy && out_free) begin
      byte_idx        <= byte_idx + gct_pkg::ColIdxW'(1);
      row_pos         <= row_pos_next;
      col_pos         <= col_pos_next;
      rows.row_byte   <= packed_byte;
      rows.page_done  <= last_byte;
      rows.glyph_done <= last_byte && cur.last_page;
    end
  end

endmodule

// ===== rtl/core/glyph_column_to_row_transpose.sv =====
// ----------------------------------------------------------------------------
// glyph_column_to_row_transpose: font column bytes to row-major bitmap bytes
// Top level with the configuration registers, the intake, the page queue
// and the row packer.
// ----------------------------------------------------------------------------
// Column bytes are taken one per cycle while the page queue has room. When
// the last column of a page arrives, the page moves into a two-page queue and
// the intake goes on with the next page at once. The packer then loads the
// page and emits one byte per column of the clamped glyph width, one per
// cycle while the output side accepts them. The last byte of each page
// carries page_done, and that of the last page glyph_done. Write glyph_width
// and page_count only while idle.
module glyph_column_to_row_transpose (
  input  logic                          clk,
  input  logic                          rst,
  gct_col_if.sink                       columns,
  gct_row_if.source                     rows,
  input  logic                          cfg_wr_en,
  input  logic [gct_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [gct_pkg::CfgDataW-1:0]  cfg_data
);

  logic [gct_pkg::WidthW-1:0] glyph_width;
  logic [gct_pkg::PagesW-1:0] page_count;
  logic                       push;
  logic                       pop;
  gct_pkg::job_t              job_in;
  gct_pkg::job_t              job_out;
  gct_pkg::q_status_t         q_status;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width <= gct_pkg::GlyphWidthReset;
      page_count  <= gct_pkg::PageCountReset;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gct_pkg::REG_GLYPH_WIDTH: glyph_width <= cfg_data;
        gct_pkg::REG_PAGE_COUNT:  page_count  <= cfg_data[gct_pkg::PagesW-1:0];
        default: ;
      endcase
    end
  end

  // Intake of column bytes.
  gct_front u_front (
    .clk      (clk),
    .rst      (rst),
    .columns  (columns),
    .width    (gct_pkg::eff_width(glyph_width)),
    .pages    (gct_pkg::eff_pages(page_count)),
    .q_status (q_status),
    .push     (push),
    .job      (job_in)
  );

  // Finished pages waiting for the packer.
  gct_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .job_in  (job_in),
    .pop     (pop),
    .job_out (job_out),
    .status  (q_status)
  );

  // Row-major packing and output.
  gct_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job      (job_out),
    .q_status (q_status),
    .pop      (pop),
    .rows     (rows)
  );

`ifndef SYNTH
  // A glyph can only end on the last byte of a page.
  a_glyph_on_page_end: assert property (@(posedge clk) disable iff (rst)
    rows.valid && rows.glyph_done |-> rows.page_done)
    else $error("glyph_done without page_done");

  // A finished page never arrives at a full queue.
  a_no_queue_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("page pushed into a full queue");

  // The packer only loads a page that the queue holds.
  a_no_queue_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty)
    else $error("page taken from an empty queue");

  // Nothing is offered in the cycle after reset.
  a_idle_after_reset: assert property (@(posedge clk)
    rst |=> !rows.valid)
    else $error("output valid right after reset");
`endif

endmodule
